>>> rtl/core/affine_box_keypoint_projector_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the affine box / keypoint projector
// Shared concurrent assertion wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef AFFINE_BOX_KEYPOINT_PROJECTOR_UNIT_DEFINES_SVH
`define AFFINE_BOX_KEYPOINT_PROJECTOR_UNIT_DEFINES_SVH

// normal checks, quiet while reset is held
`define ABKP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checks that must also hold across reset
`define ABKP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/abkp_pkg.sv
// ----------------------------------------------------------------------------
// abkp_pkg
// Register indexes, opcodes and fixed-point constants of the projector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package abkp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_REGS  = 6;
  localparam int REG_IDX_W = 3;
  localparam int NUM_TERMS = 4;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_XX  = 3'd0,
    REG_COEF_XY  = 3'd1,
    REG_OFFSET_X = 3'd2,
    REG_COEF_YX  = 3'd3,
    REG_COEF_YY  = 3'd4,
    REG_OFFSET_Y = 3'd5
  } reg_idx_t;

  // product slots for one output axis
  typedef enum logic [1:0] {
    TERM_BASE_A = 2'd0,   // coef_a * x
    TERM_BASE_B = 2'd1,   // coef_b * y
    TERM_SPAN_A = 2'd2,   // coef_a * width
    TERM_SPAN_B = 2'd3    // coef_b * height
  } term_t;

  localparam logic OP_KEYPOINT = 1'b0;
  localparam logic OP_BOX      = 1'b1;

endpackage

>>> rtl/core/abkp_mul_stage.sv
// ----------------------------------------------------------------------------
// abkp_mul_stage
// Forms the eight coefficient products of one word and registers them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abkp_mul_stage
  import abkp_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int COEF_WIDTH  = 32,
  parameter int PW          = COORD_WIDTH + COEF_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  output logic                                  dn_valid,
  input  logic                                  dn_ready,
  input  logic [NUM_REGS-1:0][COEF_WIDTH-1:0]   coef,
  input  logic                                  op,
  input  logic signed [COORD_WIDTH-1:0]         pos_x,
  input  logic signed [COORD_WIDTH-1:0]         pos_y,
  input  logic signed [COORD_WIDTH-1:0]         box_width,
  input  logic signed [COORD_WIDTH-1:0]         box_height,
  input  logic                                  relative_format,
  output logic [NUM_TERMS-1:0][PW-1:0]          prod_x,
  output logic [NUM_TERMS-1:0][PW-1:0]          prod_y,
  output logic                                  fmt_err
);

  logic                          valid_r;
  logic [NUM_TERMS-1:0][PW-1:0]  prod_x_r, prod_x_nxt;
  logic [NUM_TERMS-1:0][PW-1:0]  prod_y_r, prod_y_nxt;
  logic                          err_r;
  logic signed [COORD_WIDTH-1:0] span_w, span_h;
  logic signed [COEF_WIDTH-1:0]  c_xx, c_xy, c_yx, c_yy;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    // keypoints have no extent
    span_w = (op == OP_BOX) ? box_width  : '0;
    span_h = (op == OP_BOX) ? box_height : '0;
    c_xx   = $signed(coef[REG_COEF_XX]);
    c_xy   = $signed(coef[REG_COEF_XY]);
    c_yx   = $signed(coef[REG_COEF_YX]);
    c_yy   = $signed(coef[REG_COEF_YY]);
  end

  // PW-bit context keeps the full signed product
  assign prod_x_nxt[TERM_BASE_A] = PW'(c_xx * pos_x);
  assign prod_x_nxt[TERM_BASE_B] = PW'(c_xy * pos_y);
  assign prod_x_nxt[TERM_SPAN_A] = PW'(c_xx * span_w);
  assign prod_x_nxt[TERM_SPAN_B] = PW'(c_xy * span_h);
  assign prod_y_nxt[TERM_BASE_A] = PW'(c_yx * pos_x);
  assign prod_y_nxt[TERM_BASE_B] = PW'(c_yy * pos_y);
  assign prod_y_nxt[TERM_SPAN_A] = PW'(c_yx * span_w);
  assign prod_y_nxt[TERM_SPAN_B] = PW'(c_yy * span_h);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      err_r    <= !relative_format;
    end
  end

  assign dn_valid = valid_r;
  assign prod_x   = prod_x_r;
  assign prod_y   = prod_y_r;
  assign fmt_err  = err_r;

endmodule

>>> rtl/core/abkp_bound_stage.sv
// ----------------------------------------------------------------------------
// abkp_bound_stage
// Sums products into the min and max corner per axis, rounds, adds offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "affine_box_keypoint_projector_unit_defines.svh"

module abkp_bound_stage
  import abkp_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int COEF_WIDTH  = 32,
  parameter int PW          = COORD_WIDTH + COEF_WIDTH,
  parameter int SW          = PW + 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  input  logic [NUM_TERMS-1:0][PW-1:0]  prod_x,
  input  logic [NUM_TERMS-1:0][PW-1:0]  prod_y,
  input  logic                          fmt_err_in,
  input  logic [COEF_WIDTH-1:0]         offset_x,
  input  logic [COEF_WIDTH-1:0]         offset_y,
  output logic signed [SW-1:0]          lo_x,
  output logic signed [SW-1:0]          hi_x,
  output logic signed [SW-1:0]          lo_y,
  output logic signed [SW-1:0]          hi_y,
  output logic                          fmt_err
);

  localparam logic signed [SW-1:0] RND_HALF =
    {{(SW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  logic                 valid_r;
  logic                 err_r;
  logic signed [SW-1:0] lo_x_r, lo_x_nxt, hi_x_r, hi_x_nxt;
  logic signed [SW-1:0] lo_y_r, lo_y_nxt, hi_y_r, hi_y_nxt;

  function automatic logic signed [SW-1:0] ext_p(input logic [PW-1:0] p);
    return {{(SW-PW){p[PW-1]}}, p};
  endfunction

  function automatic logic signed [SW-1:0] neg_part(input logic [PW-1:0] p);
    return p[PW-1] ? ext_p(p) : '0;
  endfunction

  function automatic logic signed [SW-1:0] pos_part(input logic [PW-1:0] p);
    return p[PW-1] ? '0 : ext_p(p);
  endfunction

  // floor to whole fraction units, then the integer-aligned offset
  function automatic logic signed [SW-1:0] round_off(input logic signed [SW-1:0] s,
                                                    input logic [COEF_WIDTH-1:0] off);
    return (s >>> FRAC_BITS) + $signed({{(SW-COEF_WIDTH){off[COEF_WIDTH-1]}}, off});
  endfunction

  assign up_ready = !valid_r || dn_ready;

  // the map is linear, so the corner extremes come from the sign of each span term
  always_comb begin
    logic signed [SW-1:0] base_x, base_y;
    base_x   = ext_p(prod_x[TERM_BASE_A]) + ext_p(prod_x[TERM_BASE_B]) + RND_HALF;
    base_y   = ext_p(prod_y[TERM_BASE_A]) + ext_p(prod_y[TERM_BASE_B]) + RND_HALF;
    lo_x_nxt = round_off(base_x + neg_part(prod_x[TERM_SPAN_A])
                                + neg_part(prod_x[TERM_SPAN_B]), offset_x);
    hi_x_nxt = round_off(base_x + pos_part(prod_x[TERM_SPAN_A])
                                + pos_part(prod_x[TERM_SPAN_B]), offset_x);
    lo_y_nxt = round_off(base_y + neg_part(prod_y[TERM_SPAN_A])
                                + neg_part(prod_y[TERM_SPAN_B]), offset_y);
    hi_y_nxt = round_off(base_y + pos_part(prod_y[TERM_SPAN_A])
                                + pos_part(prod_y[TERM_SPAN_B]), offset_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      lo_x_r <= lo_x_nxt;
      hi_x_r <= hi_x_nxt;
      lo_y_r <= lo_y_nxt;
      hi_y_r <= hi_y_nxt;
      err_r  <= fmt_err_in;
    end
  end

  assign dn_valid = valid_r;
  assign lo_x     = lo_x_r;
  assign hi_x     = hi_x_r;
  assign lo_y     = lo_y_r;
  assign hi_y     = hi_y_r;
  assign fmt_err  = err_r;

  `ABKP_ASSERT(a_bound_order, valid_r |-> (lo_x_r <= hi_x_r) && (lo_y_r <= hi_y_r), "lo above hi")

endmodule

>>> rtl/core/abkp_sat_stage.sv
// ----------------------------------------------------------------------------
// abkp_sat_stage
// Saturates corner and size, applies the format error, holds the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abkp_sat_stage
  import abkp_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int COEF_WIDTH  = 32,
  parameter int SW          = COORD_WIDTH + COEF_WIDTH + 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [SW-1:0]          lo_x,
  input  logic signed [SW-1:0]          hi_x,
  input  logic signed [SW-1:0]          lo_y,
  input  logic signed [SW-1:0]          hi_y,
  input  logic                          fmt_err,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic [COORD_WIDTH-2:0]        out_width,
  output logic [COORD_WIDTH-2:0]        out_height,
  output logic                          out_format_error
);

  localparam logic signed [SW-1:0] C_HI =
    {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] C_LO = ~C_HI;

  logic                          valid_r;
  logic signed [COORD_WIDTH-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [COORD_WIDTH-2:0]        w_r, w_nxt, h_r, h_nxt;
  logic                          err_r;

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(input logic signed [SW-1:0] v);
    priority if (v > C_HI) begin
      return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else if (v < C_LO) begin
      return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      return v[COORD_WIDTH-1:0];
    end
  endfunction

  function automatic logic [COORD_WIDTH-2:0] sat_size(input logic signed [SW-1:0] v);
    priority if (v <= 0) begin
      return '0;
    end else if (v > C_HI) begin
      return '1;
    end else begin
      return v[COORD_WIDTH-2:0];
    end
  endfunction

  assign up_ready = !valid_r || out_ready;

  always_comb begin
    if (fmt_err) begin
      x_nxt = '0;
      y_nxt = '0;
      w_nxt = '0;
      h_nxt = '0;
    end else begin
      x_nxt = sat_coord(lo_x);
      y_nxt = sat_coord(lo_y);
      // size comes from the unsaturated corners
      w_nxt = sat_size(hi_x - lo_x);
      h_nxt = sat_size(hi_y - lo_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      w_r   <= w_nxt;
      h_r   <= h_nxt;
      err_r <= fmt_err;
    end
  end

  assign out_valid        = valid_r;
  assign out_x            = x_r;
  assign out_y            = y_r;
  assign out_width        = w_r;
  assign out_height       = h_r;
  assign out_format_error = err_r;

endmodule

>>> rtl/core/affine_box_keypoint_projector_unit.sv
// ----------------------------------------------------------------------------
// affine_box_keypoint_projector_unit
// Affine map of keypoints and boxes; boxes return their enclosing box.
// ----------------------------------------------------------------------------
//  port group | dir | words
//  in_*       | in  | op, pos_x, pos_y, box_width, box_height, relative_format
//  out_*      | out | out_x, out_y, out_width, out_height, out_format_error
//  cfg_*      | in  | coefficient write: cfg_we, cfg_index, cfg_wdata
//
//  One word per cycle sustained while out_ready stays high; each word passes through
//  the input register, multiplier register, bound register and output register.
//  The multiplier bank sets the cycle: eight COORD_WIDTH x COEF_WIDTH products
//  per word, in parallel.
//  Reset clears all stage valids and loads identity coefficients.
//  A stalled output only holds the stages that are full; bubbles collapse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "affine_box_keypoint_projector_unit_defines.svh"

module affine_box_keypoint_projector_unit
  import abkp_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int COEF_WIDTH  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_width,
  input  logic signed [COORD_WIDTH-1:0] in_box_height,
  input  logic                          in_relative_format,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic [COORD_WIDTH-2:0]        out_width,
  output logic [COORD_WIDTH-2:0]        out_height,
  output logic                          out_format_error,
  input  logic                          cfg_we,
  input  logic [REG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_WIDTH-1:0]         cfg_wdata
);

  localparam int PW = COORD_WIDTH + COEF_WIDTH;
  localparam int SW = PW + 4;
  localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(64'd1 << FRAC_BITS);

  logic [NUM_REGS-1:0][COEF_WIDTH-1:0] coef_r;

  logic                          s0_valid_r;
  logic                          s0_op_r;
  logic signed [COORD_WIDTH-1:0] s0_x_r, s0_y_r, s0_w_r, s0_h_r;
  logic                          s0_rel_r;

  logic                          mul_ready, mul_valid, mul_err;
  logic [NUM_TERMS-1:0][PW-1:0]  prod_x, prod_y;
  logic                          bnd_ready, bnd_valid, bnd_err;
  logic signed [SW-1:0]          lo_x, hi_x, lo_y, hi_y;
  logic                          sat_ready;
  logic                          out_geom_zero;

  // coefficient registers; writes past the last index are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[REG_COEF_XX]  <= COEF_ONE;
      coef_r[REG_COEF_XY]  <= '0;
      coef_r[REG_OFFSET_X] <= '0;
      coef_r[REG_COEF_YX]  <= '0;
      coef_r[REG_COEF_YY]  <= COEF_ONE;
      coef_r[REG_OFFSET_Y] <= '0;
    end else if (cfg_we && (cfg_index < REG_IDX_W'(NUM_REGS))) begin
      coef_r[cfg_index] <= cfg_wdata;
    end
  end

  assign in_ready = !s0_valid_r || mul_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_op_r  <= in_op;
      s0_x_r   <= in_pos_x;
      s0_y_r   <= in_pos_y;
      s0_w_r   <= in_box_width;
      s0_h_r   <= in_box_height;
      s0_rel_r <= in_relative_format;
    end
  end

  abkp_mul_stage #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH),
    .PW          (PW)
  ) u_mul (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (s0_valid_r),
    .up_ready        (mul_ready),
    .dn_valid        (mul_valid),
    .dn_ready        (bnd_ready),
    .coef            (coef_r),
    .op              (s0_op_r),
    .pos_x           (s0_x_r),
    .pos_y           (s0_y_r),
    .box_width       (s0_w_r),
    .box_height      (s0_h_r),
    .relative_format (s0_rel_r),
    .prod_x          (prod_x),
    .prod_y          (prod_y),
    .fmt_err         (mul_err)
  );

  abkp_bound_stage #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH),
    .PW          (PW),
    .SW          (SW)
  ) u_bound (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (mul_valid),
    .up_ready   (bnd_ready),
    .dn_valid   (bnd_valid),
    .dn_ready   (sat_ready),
    .prod_x     (prod_x),
    .prod_y     (prod_y),
    .fmt_err_in (mul_err),
    .offset_x   (coef_r[REG_OFFSET_X]),
    .offset_y   (coef_r[REG_OFFSET_Y]),
    .lo_x       (lo_x),
    .hi_x       (hi_x),
    .lo_y       (lo_y),
    .hi_y       (hi_y),
    .fmt_err    (bnd_err)
  );

  abkp_sat_stage #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH),
    .SW          (SW)
  ) u_sat (
    .clk              (clk),
    .rst_n            (rst_n),
    .up_valid         (bnd_valid),
    .up_ready         (sat_ready),
    .lo_x             (lo_x),
    .hi_x             (hi_x),
    .lo_y             (lo_y),
    .hi_y             (hi_y),
    .fmt_err          (bnd_err),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_width        (out_width),
    .out_height       (out_height),
    .out_format_error (out_format_error)
  );

  assign out_geom_zero = (out_x == '0) && (out_y == '0) && (out_width == '0)
                         && (out_height == '0);

  `ABKP_ASSERT_RST(a_rst_clears_input, !rst_n |=> !s0_valid_r, "input stage valid after reset")
  `ABKP_ASSERT(a_ready_only_when_full, !in_ready |-> s0_valid_r, "input stalled while empty")
  `ABKP_ASSERT(a_err_zero_fields, out_valid && out_format_error |-> out_geom_zero, "error geometry")

endmodule

>>> tb/projection_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// projection_checker
// Watches the projector's input, result and coefficient ports. It keeps its
// own copy of the six affine registers, predicts every accepted word and
// compares each result word in order against the oldest prediction.
// ----------------------------------------------------------------------------

module projection_checker
  import abkp_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int COEF_WIDTH  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_op,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_width,
  input  logic signed [COORD_WIDTH-1:0] in_box_height,
  input  logic                          in_relative_format,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [COORD_WIDTH-1:0] out_x,
  input  logic signed [COORD_WIDTH-1:0] out_y,
  input  logic [COORD_WIDTH-2:0]        out_width,
  input  logic [COORD_WIDTH-2:0]        out_height,
  input  logic                          out_format_error,
  input  logic                          cfg_we,
  input  logic [REG_IDX_W-1:0]          cfg_index,
  input  logic [COEF_WIDTH-1:0]         cfg_wdata,
  output int                            mismatch_count,
  output int                            pending_count
);

  localparam int     SIZE_WIDTH   = COORD_WIDTH - 1;
  localparam longint COORD_MAX    = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN    = -COORD_MAX - 1;
  localparam int     REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic [SIZE_WIDTH-1:0]         width;
    logic [SIZE_WIDTH-1:0]         height;
    logic                          format_error;
  } projection_t;

  longint      coef [NUM_REGS];
  projection_t projections_due [$];

  function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(input longint v);
    return COORD_WIDTH'(v > COORD_MAX ? COORD_MAX : (v < COORD_MIN ? COORD_MIN : v));
  endfunction

  function automatic logic [SIZE_WIDTH-1:0] clamp_size(input longint v);
    return SIZE_WIDTH'(v <= 0 ? 64'sd0 : (v > COORD_MAX ? COORD_MAX : v));
  endfunction

  // exact a*x + b*y in Q.16, rounded once (ties up), then the offset as a Q.0 integer
  function automatic longint map_axis(input longint a, input longint b, input longint off,
                                      input longint x, input longint y);
    longint acc;
    acc = a * x + b * y + (64'sd1 <<< (FRAC_BITS - 1));
    return (acc >>> FRAC_BITS) + off;
  endfunction

  function automatic projection_t project_word(input logic op, input longint x,
                                               input longint y, input longint w,
                                               input longint h, input logic rel);
    projection_t r;
    longint      corner_x [4];
    longint      corner_y [4];
    longint      mx, my, min_x, max_x, min_y, max_y;
    int          i;
    r = '0;
    if (!rel) begin
      r.format_error = 1'b1;
      return r;
    end
    if (op == OP_KEYPOINT) begin
      r.x = clamp_coord(map_axis(coef[REG_COEF_XX], coef[REG_COEF_XY], coef[REG_OFFSET_X], x, y));
      r.y = clamp_coord(map_axis(coef[REG_COEF_YX], coef[REG_COEF_YY], coef[REG_OFFSET_Y], x, y));
      return r;
    end
    corner_x[0] = x;     corner_y[0] = y;
    corner_x[1] = x + w; corner_y[1] = y;
    corner_x[2] = x + w; corner_y[2] = y + h;
    corner_x[3] = x;     corner_y[3] = y + h;
    min_x = 0; max_x = 0; min_y = 0; max_y = 0;
    for (i = 0; i < 4; i++) begin
      mx = map_axis(coef[REG_COEF_XX], coef[REG_COEF_XY], coef[REG_OFFSET_X],
                    corner_x[i], corner_y[i]);
      my = map_axis(coef[REG_COEF_YX], coef[REG_COEF_YY], coef[REG_OFFSET_Y],
                    corner_x[i], corner_y[i]);
      if (i == 0 || mx < min_x) min_x = mx;
      if (i == 0 || mx > max_x) max_x = mx;
      if (i == 0 || my < min_y) min_y = my;
      if (i == 0 || my > max_y) max_y = my;
    end
    // size comes from the unsaturated corners
    r.x      = clamp_coord(min_x);
    r.y      = clamp_coord(min_y);
    r.width  = clamp_size(max_x - min_x);
    r.height = clamp_size(max_y - min_y);
    return r;
  endfunction

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  always @(posedge clk) begin
    projection_t seen;
    projection_t want;
    if (!rst_n) begin
      coef[REG_COEF_XX]  = 64'sd1 <<< FRAC_BITS;
      coef[REG_COEF_XY]  = 0;
      coef[REG_OFFSET_X] = 0;
      coef[REG_COEF_YX]  = 0;
      coef[REG_COEF_YY]  = 64'sd1 <<< FRAC_BITS;
      coef[REG_OFFSET_Y] = 0;
      projections_due.delete();
    end else begin
      // retire first: a word accepted this edge cannot leave this edge
      if (out_valid && out_ready) begin
        seen.x            = out_x;
        seen.y            = out_y;
        seen.width        = out_width;
        seen.height       = out_height;
        seen.format_error = out_format_error;
        if (projections_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result word with none expected: x=%0d y=%0d w=%0d h=%0d err=%b",
                     $time, seen.x, seen.y, seen.width, seen.height, seen.format_error);
        end else begin
          want = projections_due.pop_front();
          if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: result mismatch: expected x=%0d y=%0d w=%0d h=%0d err=%b,",
                       $time, want.x, want.y, want.width, want.height, want.format_error,
                       " got x=%0d y=%0d w=%0d h=%0d err=%b",
                       seen.x, seen.y, seen.width, seen.height, seen.format_error);
          end
        end
      end
      if (in_valid && in_ready)
        projections_due.insert(projections_due.size(),
                               project_word(in_op, longint'(in_pos_x), longint'(in_pos_y),
                                            longint'(in_box_width),
                                            longint'(in_box_height),
                                            in_relative_format));
      if (cfg_we && cfg_index < NUM_REGS)
        coef[cfg_index] = longint'(signed'(cfg_wdata));
    end
    pending_count = projections_due.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives keypoint and box words through the affine projector under a series
// of coefficient settings (identity, extremes, rounding ties, zero, random)
// with random idle bursts on both channels and one long output stall.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------

module testbench;
  import abkp_pkg::*;

  localparam int COORD_WIDTH     = 24;
  localparam int COEF_WIDTH      = 32;
  localparam int PHASES          = 11;
  localparam int WORDS_PER_PHASE = 75;
  localparam int PIPE_DEPTH      = 4;
  localparam int LONG_HOLD       = 80;

  localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [COEF_WIDTH-1:0]  K_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic [COEF_WIDTH-1:0]  K_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};
  localparam logic [COEF_WIDTH-1:0]  K_ONE = COEF_WIDTH'(1 << FRAC_BITS);

  logic                          clk;
  logic                          rst_n              = 1'b0;
  logic                          in_valid           = 1'b0;
  logic                          in_op              = OP_KEYPOINT;
  logic signed [COORD_WIDTH-1:0] in_pos_x           = '0;
  logic signed [COORD_WIDTH-1:0] in_pos_y           = '0;
  logic signed [COORD_WIDTH-1:0] in_box_width       = '0;
  logic signed [COORD_WIDTH-1:0] in_box_height      = '0;
  logic                          in_relative_format = 1'b0;
  logic                          out_ready          = 1'b0;
  logic                          cfg_we             = 1'b0;
  logic [REG_IDX_W-1:0]          cfg_index          = '0;
  logic [COEF_WIDTH-1:0]         cfg_wdata          = '0;

  wire                           in_ready;
  wire                           out_valid;
  wire signed [COORD_WIDTH-1:0]  out_x;
  wire signed [COORD_WIDTH-1:0]  out_y;
  wire [COORD_WIDTH-2:0]         out_width;
  wire [COORD_WIDTH-2:0]         out_height;
  wire                           out_format_error;

  int mismatch_count;
  int pending_count;

  bit calm          = 1'b0;  // no idling in the last phase
  bit long_hold_req = 1'b0;

  affine_box_keypoint_projector_unit #(
    .COORD_WIDTH(COORD_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) DUT (.*);

  projection_checker #(
    .COORD_WIDTH(COORD_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // result side: random back-pressure, plus one long hold on request
  initial begin
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_word(input logic op, input logic [COORD_WIDTH-1:0] px,
                           input logic [COORD_WIDTH-1:0] py,
                           input logic [COORD_WIDTH-1:0] bw,
                           input logic [COORD_WIDTH-1:0] bh, input logic rel);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_op              <= op;
    in_pos_x           <= px;
    in_pos_y           <= py;
    in_box_width       <= bw;
    in_box_height      <= bh;
    in_relative_format <= rel;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic put_reg(input reg_idx_t idx, input logic [COEF_WIDTH-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic load_affine(input logic [COEF_WIDTH-1:0] xx, input logic [COEF_WIDTH-1:0] xy,
                             input logic [COEF_WIDTH-1:0] ox, input logic [COEF_WIDTH-1:0] yx,
                             input logic [COEF_WIDTH-1:0] yy, input logic [COEF_WIDTH-1:0] oy);
    put_reg(REG_COEF_XX, xx);
    put_reg(REG_COEF_XY, xy);
    put_reg(REG_OFFSET_X, ox);
    put_reg(REG_COEF_YX, yx);
    put_reg(REG_COEF_YY, yy);
    put_reg(REG_OFFSET_Y, oy);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // half small coordinates so the map stays in range, a quarter full-range, a quarter extremes
  function automatic logic [COORD_WIDTH-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0:       return COORD_WIDTH'($urandom);
      1:       return $urandom_range(0, 1) ? C_MAX : C_MIN;
      default: return COORD_WIDTH'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  function automatic logic [COEF_WIDTH-1:0] spread(input int span);
    return COEF_WIDTH'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  initial begin
    int phase;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at identity coefficients
    send_word(OP_KEYPOINT, '0, '0, '0, '0, 1'b1);
    send_word(OP_KEYPOINT, C_MAX, C_MAX, '0, '0, 1'b1);
    send_word(OP_KEYPOINT, C_MIN, C_MIN, '0, '0, 1'b1);
    send_word(OP_KEYPOINT, C_MAX, C_MIN, C_MAX, C_MIN, 1'b1);   // size ignored
    send_word(OP_BOX, '0, '0, '0, '0, 1'b1);
    send_word(OP_BOX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1);        // corners overflow
    send_word(OP_BOX, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1);
    send_word(OP_BOX, C_MIN, C_MIN, C_MAX, C_MAX, 1'b1);
    send_word(OP_BOX, C_MAX, C_MAX, C_MIN, C_MIN, 1'b1);        // negative size
    send_word(OP_BOX, 'h03_8000, 'hFE_0000, 'hFF_4000, 'hFD_C000, 1'b1);
    send_word(OP_BOX, 'h01_0000, 'h02_0000, 'h00_0000, 'h05_0000, 1'b1);
    send_word(OP_BOX, 'h10_0000, 'h20_0000, 'h04_0000, 'h03_0000, 1'b1);
    send_word(OP_KEYPOINT, C_MAX, 'h12_3456, C_MAX, C_MAX, 1'b0); // format error
    send_word(OP_BOX, 'h01_0000, 'h01_0000, 'h01_0000, 'h01_0000, 1'b0);
    send_word(OP_BOX, C_MIN, C_MAX, C_MIN, C_MAX, 1'b0);

    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        1: load_affine(K_MAX, K_MAX, K_MAX, K_MAX, K_MAX, K_MAX);
        2: load_affine(K_MIN, K_MIN, K_MIN, K_MIN, K_MIN, K_MIN);
        3: begin
          // half weights: odd inputs land exactly on rounding ties
          load_affine('h0000_8000, 'hFFFF_8000, 'h0000_0001,
                      'h0000_8000, 'h0000_8000, 'hFFFF_FFFF);
          long_hold_req = 1'b1;
        end
        4: load_affine('0, '0, '0, '0, '0, '0);
        8: load_affine($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        9: load_affine(spread(1 << 17), spread(1 << 17), $urandom,
                       spread(1 << 17), spread(1 << 17), $urandom);
        PHASES - 1: begin
          load_affine(K_ONE, '0, '0, '0, K_ONE, '0);
          calm = 1'b1;
        end
        default: load_affine(spread(1 << 17), spread(1 << 17), spread(1 << 22),
                             spread(1 << 17), spread(1 << 17), spread(1 << 22));
      endcase
      repeat (WORDS_PER_PHASE)
        send_word($urandom_range(0, 1) ? OP_BOX : OP_KEYPOINT, pick_coord(), pick_coord(),
                  pick_coord(), pick_coord(), $urandom_range(0, 7) != 0);
    end

    drain();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/abkp_pkg.sv
rtl/core/abkp_mul_stage.sv
rtl/core/abkp_bound_stage.sv
rtl/core/abkp_sat_stage.sv
rtl/core/affine_box_keypoint_projector_unit.sv
tb/projection_checker.sv
tb/testbench.sv
